// ===== rtl/scc_pkg.sv =====
// Shared types and constants for the second-chance clock replacement block.
// No dependencies; imported by scc_cell and the top level.
`timescale 1ns / 1ps
package scc_pkg;

  localparam int FRAMES_DEF = 16;
  localparam int PAGE_W     = 5;
  localparam int FAULT_W    = 32;
  localparam int IN_W       = 8;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic              hit_upd;
    logic              step;
    logic              wr;
    logic [PAGE_W-1:0] page;
  } scc_cmd_t;

  // Per-cell status; victim fields are zero unless the cell holds the hand.
  typedef struct packed {
    logic              match;
    logic              stop;
    logic              token;
    logic              vic_valid;
    logic              vic_dirty;
    logic [PAGE_W-1:0] vic_page;
  } scc_stat_t;

endpackage

// ===== rtl/second_chance_clock_replacement.sv =====
// Second-chance (clock) page replacement over a ring of FRAMES frame cells.
// A hit first takes the beat, then does the parallel page compare across all
// cells. A fault does the same and then sweeps, since the hand is a token that
// moves one cell per cycle around the ring while it passes set reference bits;
// the fill at the first clear bit waits while the result output is stalled.
// Depends on scc_pkg and scc_cell.
`timescale 1ns / 1ps
module second_chance_clock_replacement #(
  parameter int FRAMES = scc_pkg::FRAMES_DEF,
  parameter int FW     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int OUT_W  = ((3 + FW + scc_pkg::PAGE_W + scc_pkg::FAULT_W + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [4:0] page_number, [5] is_write, upper bits zero
  input  logic [scc_pkg::IN_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // hit, frame_index, victim_valid, victim_page, victim_dirty, fault_count
  output logic [OUT_W-1:0]         m_axis_tdata
);
  import scc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SWEEP} state_e;

  localparam int PAY_W = 3 + FW + PAGE_W + FAULT_W;

  state_e             state_q;
  logic [PAGE_W-1:0]  req_page_q;
  logic               req_wr_q;
  logic [FAULT_W-1:0] faults_q;
  logic               out_valid_q;
  logic               o_hit_q;
  logic [FW-1:0]      o_frame_q;
  logic               o_vvalid_q;
  logic [PAGE_W-1:0]  o_vpage_q;
  logic               o_vdirty_q;
  logic [FAULT_W-1:0] o_fault_q;

  scc_cmd_t           cmd;
  scc_stat_t          stat [FRAMES];
  logic [FRAMES-1:0]  pass;
  logic [FRAMES-1:0]  match_vec;
  logic [FRAMES-1:0]  token_vec;
  logic [FRAMES-1:0]  stop_vec;
  logic               hit_any;
  logic               stop_any;
  logic               out_free;
  logic               emit;
  logic [FW-1:0]      match_idx;
  logic [FW-1:0]      token_idx;
  logic               vic_valid;
  logic               vic_dirty;
  logic [PAGE_W-1:0]  vic_page;
  logic [FAULT_W-1:0] faults_inc;

  assign out_free = !out_valid_q || m_axis_tready;

  assign cmd.hit_upd = (state_q == S_LOOK) && out_free;
  assign cmd.step    = (state_q == S_SWEEP) && (!stop_any || out_free);
  assign cmd.wr      = req_wr_q;
  assign cmd.page    = req_page_q;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    scc_cell #(
      .HOME ((g == 0) ? 1'b1 : 1'b0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .pass_i (pass[(g + FRAMES - 1) % FRAMES]),
      .pass_o (pass[g]),
      .stat_o (stat[g])
    );
    assign match_vec[g] = stat[g].match;
    assign token_vec[g] = stat[g].token;
    assign stop_vec[g]  = stat[g].stop;
  end

  assign hit_any  = |match_vec;
  assign stop_any = |stop_vec;

  // a result beat is loaded on a hit or when the sweep fills a frame
  assign emit = ((state_q == S_LOOK) && hit_any && out_free) || (cmd.step && stop_any);

  // Encode the one-hot vectors and gather the victim from the hand's cell.
  always_comb begin
    match_idx = '0;
    token_idx = '0;
    vic_valid = 1'b0;
    vic_dirty = 1'b0;
    vic_page  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (match_vec[i]) match_idx = match_idx | FW'(i);
      if (token_vec[i]) token_idx = token_idx | FW'(i);
      vic_valid = vic_valid | stat[i].vic_valid;
      vic_dirty = vic_dirty | stat[i].vic_dirty;
      vic_page  = vic_page | stat[i].vic_page;
    end
  end

  assign faults_inc = (faults_q == '1) ? faults_q : faults_q + FAULT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_page_q  <= '0;
      req_wr_q    <= 1'b0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
      o_hit_q     <= 1'b0;
      o_frame_q   <= '0;
      o_vvalid_q  <= 1'b0;
      o_vpage_q   <= '0;
      o_vdirty_q  <= 1'b0;
      o_fault_q   <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_page_q <= s_axis_tdata[PAGE_W-1:0];
            req_wr_q   <= s_axis_tdata[PAGE_W];
            state_q    <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (!hit_any) begin
            state_q <= S_SWEEP;
          end else if (out_free) begin
            o_hit_q     <= 1'b1;
            o_frame_q   <= match_idx;
            o_vvalid_q  <= 1'b0;
            o_vpage_q   <= '0;
            o_vdirty_q  <= 1'b0;
            o_fault_q   <= faults_q;
            state_q     <= S_IDLE;
          end
        end
        S_SWEEP: begin
          // fill happens when the hand rests on a clear reference bit and the output is free
          if (cmd.step && stop_any) begin
            faults_q    <= faults_inc;
            o_hit_q     <= 1'b0;
            o_frame_q   <= token_idx;
            o_vvalid_q  <= vic_valid;
            o_vpage_q   <= vic_page;
            o_vdirty_q  <= vic_dirty;
            o_fault_q   <= faults_inc;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W - PAY_W){1'b0}}, o_fault_q, o_vdirty_q, o_vpage_q,
                          o_vvalid_q, o_frame_q, o_hit_q};

`ifndef NO_ASSERTIONS
  a_one_hand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(token_vec))
    else $error("clock hand token lost or duplicated");

  a_unique_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("page resident in more than one frame");

  a_fill_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step && stop_any) |=> (out_valid_q && !o_hit_q && state_q == S_IDLE))
    else $error("fill did not produce a fault beat");

  a_hit_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_hit_q) |-> (!o_vvalid_q && !o_vdirty_q))
    else $error("hit beat carries a victim");
`endif

endmodule

// ===== rtl/scc_cell.sv =====
// One frame of the clock ring: valid, page, reference and dirty bits plus
// the hand token that walks from cell to cell. Depends on scc_pkg.
`timescale 1ns / 1ps
module scc_cell #(
  parameter logic HOME = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scc_pkg::scc_cmd_t cmd_i,
  input  logic              pass_i,
  output logic              pass_o,
  output scc_pkg::scc_stat_t stat_o
);
  import scc_pkg::*;

  logic              valid_q, valid_d;
  logic              ref_q, ref_d;
  logic              dirty_q, dirty_d;
  logic              token_q, token_d;
  logic [PAGE_W-1:0] page_q;
  logic              match;
  logic              own_step;
  logic              fill;
  logic              hit_here;

  assign match    = valid_q && (page_q == cmd_i.page);
  assign own_step = cmd_i.step && token_q;
  assign fill     = own_step && !ref_q;
  assign hit_here = cmd_i.hit_upd && match;
  assign pass_o   = own_step;

  always_comb begin
    valid_d = valid_q | fill;
    ref_d   = ref_q;
    dirty_d = dirty_q;
    token_d = token_q;
    if (fill) begin
      ref_d   = 1'b1;
      dirty_d = cmd_i.wr;
    end else if (own_step) begin
      // second chance: clear and pass over
      ref_d = 1'b0;
    end else if (hit_here) begin
      ref_d = 1'b1;
      if (cmd_i.wr) dirty_d = 1'b1;
    end
    if (pass_i) begin
      token_d = 1'b1;
    end else if (own_step) begin
      token_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      dirty_q <= 1'b0;
      token_q <= HOME;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
      dirty_q <= dirty_d;
      token_q <= token_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) page_q <= cmd_i.page;
  end

  assign stat_o.match     = match;
  assign stat_o.stop      = token_q && !ref_q;
  assign stat_o.token     = token_q;
  assign stat_o.vic_valid = token_q && valid_q;
  assign stat_o.vic_dirty = token_q && valid_q && dirty_q;
  assign stat_o.vic_page  = (token_q && valid_q) ? page_q : '0;

endmodule

// ===== bench/second_chance_clock_replacement_tb.sv =====
// Self-checking bench for the second-chance clock replacement block: a queue-fed
// stream driver with bursty sends, a stalling result monitor and a frame-table predictor.
// Depends on scc_pkg and the second_chance_clock_replacement RTL.
`timescale 1ns / 1ps
module second_chance_clock_replacement_tb;

  localparam int FRAMES      = 16;
  localparam int OUT_W       = ((3 + 4 + scc_pkg::PAGE_W + scc_pkg::FAULT_W + 7) / 8) * 8;
  localparam int RANDOM_CNT  = 1430;
  localparam int DRAIN_CYC   = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       wr;
    logic [4:0] page;
  } access_req_t;

  // Same bit order as the result beat, hit in bit 0.
  typedef struct packed {
    logic [31:0] fault_count;
    logic        victim_dirty;
    logic [4:0]  victim_page;
    logic        victim_valid;
    logic [3:0]  frame_index;
    logic        hit;
  } access_outcome_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [scc_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_W-1:0]         m_axis_tdata;

  access_req_t     pending_accesses[$];
  access_outcome_t expected_outcomes[$];
  access_req_t     next_req;

  // Predicted frame table
  logic        frame_used[FRAMES];
  logic [4:0]  frame_owner[FRAMES];
  logic        frame_ref[FRAMES];
  logic        frame_mod[FRAMES];
  logic [3:0]  hand_pos;
  logic [31:0] fault_total;

  int burst_left, gap_left, stall_left, run_left;
  int err_count, hits_checked, faults_checked, dirty_evicts, cycle_count;

  second_chance_clock_replacement uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic queue_access(input logic [4:0] pg, input logic wr);
    access_req_t r;
    r.page = pg;
    r.wr   = wr;
    pending_accesses.push_back(r);
  endtask

  // Look the page up, sweep on a fault, and queue the outcome.
  task automatic apply_access(input logic [4:0] pg, input logic wr);
    access_outcome_t o;
    logic            found;
    logic [3:0]      slot;
    found = 1'b0;
    slot  = '0;
    o     = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (frame_used[f] && frame_owner[f] == pg) begin
        found = 1'b1;
        slot  = 4'(f);
      end
    end
    if (found) begin
      frame_ref[slot] = 1'b1;
      if (wr) frame_mod[slot] = 1'b1;
    end else begin
      if (fault_total != '1) fault_total = fault_total + 1;
      slot = hand_pos;
      // clear and pass over referenced frames; ends because each pass clears
      while (frame_ref[slot]) begin
        frame_ref[slot] = 1'b0;
        slot = slot + 4'd1;
      end
      if (frame_used[slot]) begin
        o.victim_valid = 1'b1;
        o.victim_page  = frame_owner[slot];
        o.victim_dirty = frame_mod[slot];
      end
      frame_used[slot]  = 1'b1;
      frame_owner[slot] = pg;
      frame_ref[slot]   = 1'b1;
      frame_mod[slot]   = wr;
      hand_pos          = slot + 4'd1;
    end
    o.hit         = found;
    o.frame_index = slot;
    o.fault_count = fault_total;
    expected_outcomes.push_back(o);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: bursts of beats with random gaps in between.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left    <= 1;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        apply_access(s_axis_tdata[4:0], s_axis_tdata[5]);
      // hold a beat that has not been taken
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          next_req = pending_accesses.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, next_req.wr, next_req.page};
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat, stall in runs, with quiet stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      run_left      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outcomes.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected, actual %h", $time, m_axis_tdata);
        end else begin
          access_outcome_t e, a;
          e = expected_outcomes.pop_front();
          a = access_outcome_t'(m_axis_tdata[$bits(access_outcome_t)-1:0]);
          check_field("hit", 32'(e.hit), 32'(a.hit));
          check_field("frame_index", 32'(e.frame_index), 32'(a.frame_index));
          check_field("victim_valid", 32'(e.victim_valid), 32'(a.victim_valid));
          check_field("victim_page", 32'(e.victim_page), 32'(a.victim_page));
          check_field("victim_dirty", 32'(e.victim_dirty), 32'(a.victim_dirty));
          check_field("fault_count", e.fault_count, a.fault_count);
          if (e.hit) hits_checked++;
          else faults_checked++;
          if (e.victim_dirty) dirty_evicts++;
        end
      end
      if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (run_left > 0) begin
          run_left <= run_left - 1;
        end else begin
          run_left   <= $urandom_range(0, 12);
          stall_left <= (cycle_count[10:9] == 2'd0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int hot_base, hot_span, seq_left;
    logic [4:0] pg;
    err_count      = 0;
    hits_checked   = 0;
    faults_checked = 0;
    dirty_evicts   = 0;
    cycle_count    = 0;
    hand_pos       = '0;
    fault_total    = '0;
    for (int f = 0; f < FRAMES; f++) begin
      frame_used[f]  = 1'b0;
      frame_owner[f] = '0;
      frame_ref[f]   = 1'b0;
      frame_mod[f]   = 1'b0;
    end

    // Fill every empty frame in hand order, odd pages written.
    for (int p = 0; p < FRAMES; p++)
      queue_access(5'(p), 1'(p));
    queue_access(5'd5, 1'b1);   // write hit on a frame that is already dirty
    queue_access(5'd2, 1'b0);   // read hit
    queue_access(5'd31, 1'b1);  // every bit set: full sweep back to the hand
    queue_access(5'd31, 1'b0);
    queue_access(5'd16, 1'b0);
    queue_access(5'd17, 1'b1);
    queue_access(5'd1, 1'b0);   // evicted earlier: fault with a dirty victim

    // Drifting working sets, some wider than the frame count, plus noise.
    hot_base = 0;
    hot_span = 8;
    seq_left = 0;
    for (int i = 0; i < RANDOM_CNT; i++) begin
      if (seq_left == 0) begin
        seq_left = $urandom_range(20, 80);
        hot_base = $urandom_range(0, 31);
        hot_span = $urandom_range(4, 24);
      end
      seq_left--;
      if ($urandom_range(0, 9) < 8)
        pg = 5'((hot_base + $urandom_range(0, hot_span - 1)) % 32);
      else
        pg = 5'($urandom_range(0, 31));
      queue_access(pg, 1'($urandom_range(0, 1)));
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_accesses.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("checked %0d hits and %0d faults (%0d dirty evictions)",
             hits_checked, faults_checked, dirty_evicts);
    $display("sender bursts and receiver stalls over %0d cycles", cycle_count);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d field mismatches", err_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
